/* hw/rtl/jbr_pkg.sv */
package jbr_pkg;

    localparam int FILL_W    = 13;
    localparam int TGT_W     = 12;
    localparam int SAMPLE_W  = 32;
    localparam int REQ_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 13;

    localparam logic [FILL_W-1:0] CAP_RESET = 13'd4096;
    localparam logic [TGT_W-1:0]  TGT_RESET = 12'd480;
    // largest value the capacity register can hold
    localparam int CAP_REG_MAX = 8191;

    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_PULL  = 2'd1,
        MODE_FLUSH = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAPACITY = 2'd0,
        REG_TARGET   = 2'd1,
        REG_UNUSED2  = 2'd2,
        REG_UNUSED3  = 2'd3
    } reg_idx_t;

    typedef enum logic {
        ST_IDLE,
        ST_PULL
    } state_t;

    typedef struct packed {
        logic              last;
        logic              none;
        logic [FILL_W-1:0] fill;
        logic              rdy;
    } res_meta_t;

    typedef struct packed {
        logic      valid;
        res_meta_t meta;
    } issue_t;

endpackage

/* hw/rtl/jbr_mem.sv */
module jbr_mem
    import jbr_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
)
(
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  logic [SAMPLE_W-1:0] wdata,
    input  logic                re,
    input  logic [AW-1:0]       raddr,
    output logic [SAMPLE_W-1:0] rdata
);

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/jbr_outq.sv */
module jbr_outq
    import jbr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  issue_t              iss,
    input  logic [SAMPLE_W-1:0] rdata,
    output logic                slot_ok,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [47:0]         m_tdata,   // sample_out[31:0], fill_level[44:32]
    output logic [1:0]          m_tuser,   // none_delivered[0], ready_res[1]
    output logic                m_tlast
);

    logic                infl_reg;
    res_meta_t           meta_d_reg;
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic [1:0]          cnt_reg;
    logic [SAMPLE_W-1:0] q_sample_reg [2];
    res_meta_t           q_meta_reg [2];

    logic                pop;
    logic [SAMPLE_W-1:0] arr_sample;
    logic [2:0]          occ;
    res_meta_t           head_meta;

    assign pop        = m_tvalid && m_tready;
    assign m_tvalid   = (cnt_reg != 2'd0);
    assign occ        = {1'b0, cnt_reg} + {2'b00, infl_reg};
    // a new read may go out if its data has a slot when it lands
    assign slot_ok    = pop || (occ < 3'd2);
    assign arr_sample = meta_d_reg.none ? '0 : rdata;
    assign head_meta  = q_meta_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            infl_reg   <= 1'b0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            infl_reg <= iss.valid;
            if (infl_reg)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= 2'(occ - {2'b00, pop});
        end
    end

    always_ff @(posedge clk)
    begin
        meta_d_reg <= iss.meta;
        if (infl_reg)
        begin
            q_sample_reg[wr_ptr_reg] <= arr_sample;
            q_meta_reg[wr_ptr_reg]   <= meta_d_reg;
        end
    end

    assign m_tdata = {3'b000, head_meta.fill, q_sample_reg[rd_ptr_reg]};
    assign m_tuser = {head_meta.rdy, head_meta.none};
    assign m_tlast = head_meta.last;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output queue count out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        infl_reg |-> cnt_reg != 2'd2)
        else $error("read data landed on a full output queue");

    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        occ <= 3'd2)
        else $error("queued plus in-flight items exceed two");

endmodule

/* hw/rtl/jbr_ctrl.sv */
module jbr_ctrl
    import jbr_pkg::*;
#(
    parameter int DEPTH    = 4096,
    parameter int MAX_PULL = 64,
    parameter int AW       = 12
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [1:0]           mode,
    input  logic [SAMPLE_W-1:0]  sample_in,
    input  logic [REQ_W-1:0]     request_count,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 slot_ok,
    output logic                 mem_we,
    output logic [AW-1:0]        mem_waddr,
    output logic [SAMPLE_W-1:0]  mem_wdata,
    output logic                 mem_re,
    output logic [AW-1:0]        mem_raddr,
    output issue_t               iss
);

    localparam int SW         = ((AW > FILL_W) ? AW : FILL_W) + 1;
    localparam int DEPTH_CLIP = (DEPTH > CAP_REG_MAX) ? CAP_REG_MAX : DEPTH;
    localparam logic [FILL_W-1:0] DEPTH_C = FILL_W'(DEPTH_CLIP);
    localparam logic [REQ_W-1:0]  MAX_C   = REQ_W'(MAX_PULL);

    state_t            state_reg,   state_next;
    logic [AW-1:0]     head_reg,    head_next;
    logic [FILL_W-1:0] fill_reg,    fill_next;
    logic              started_reg, started_next;
    logic [REQ_W-1:0]  cnt_reg,     cnt_next;
    logic              empty_reg,   empty_next;
    logic [FILL_W-1:0] cap_cfg_reg, cap_cfg_next;
    logic [TGT_W-1:0]  tgt_cfg_reg, tgt_cfg_next;

    logic [TGT_W-1:0]  eff_tgt;
    logic [FILL_W-1:0] cap_a, cap_b, eff_cap;
    logic [SW-1:0]     pos_sum, pos_wrap, h_sum;
    logic [AW-1:0]     h_inc;
    logic [REQ_W-1:0]  req_sat;
    logic              s_accept;
    logic              full;
    logic              gate_shut;
    logic [FILL_W-1:0] fill_dec;
    mode_t             mode_e;
    reg_idx_t          idx_e;

    // effective target and capacity
    always_comb
    begin
        eff_tgt = (tgt_cfg_reg == '0) ? TGT_W'(1) : tgt_cfg_reg;
        cap_a   = (cap_cfg_reg > DEPTH_C) ? DEPTH_C : cap_cfg_reg;
        cap_b   = (cap_a <= {1'b0, eff_tgt}) ? ({1'b0, eff_tgt} + FILL_W'(1)) : cap_a;
        eff_cap = (cap_b > DEPTH_C) ? DEPTH_C : cap_b;
    end

    // ring arithmetic: head < cap and fill <= cap, so one subtract wraps
    always_comb
    begin
        pos_sum  = SW'(head_reg) + SW'(fill_reg);
        pos_wrap = (pos_sum >= SW'(eff_cap)) ? (pos_sum - SW'(eff_cap)) : pos_sum;
        h_sum    = SW'(head_reg) + SW'(1);
        h_inc    = (h_sum >= SW'(eff_cap)) ? '0 : h_sum[AW-1:0];
    end

    assign s_accept  = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign full      = (fill_reg == eff_cap);
    assign req_sat   = (request_count > MAX_C) ? MAX_C : request_count;
    assign gate_shut = !started_reg && (fill_reg < {1'b0, eff_tgt});
    assign fill_dec  = fill_reg - FILL_W'(1);
    assign mode_e    = mode_t'(mode);
    assign idx_e     = reg_idx_t'(cfg_index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            fill_reg    <= '0;
            started_reg <= 1'b0;
            cnt_reg     <= '0;
            empty_reg   <= 1'b0;
            cap_cfg_reg <= CAP_RESET;
            tgt_cfg_reg <= TGT_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            fill_reg    <= fill_next;
            started_reg <= started_next;
            cnt_reg     <= cnt_next;
            empty_reg   <= empty_next;
            cap_cfg_reg <= cap_cfg_next;
            tgt_cfg_reg <= tgt_cfg_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        fill_next    = fill_reg;
        started_next = started_reg;
        cnt_next     = cnt_reg;
        empty_next   = empty_reg;
        cap_cfg_next = cap_cfg_reg;
        tgt_cfg_next = tgt_cfg_reg;
        mem_we       = 1'b0;
        mem_waddr    = pos_wrap[AW-1:0];
        mem_wdata    = sample_in;
        mem_re       = 1'b0;
        mem_raddr    = head_reg;
        iss          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    unique case (mode_e)
                        MODE_PUSH:
                        begin
                            mem_we = 1'b1;
                            if (full)
                            begin
                                head_next = h_inc;
                            end
                            else
                            begin
                                fill_next = fill_reg + FILL_W'(1);
                            end
                        end
                        MODE_PULL:
                        begin
                            state_next = ST_PULL;
                            empty_next = (req_sat == '0) || gate_shut || (fill_reg == '0);
                            cnt_next   = (fill_reg < FILL_W'(req_sat)) ?
                                         REQ_W'(fill_reg) : req_sat;
                        end
                        MODE_FLUSH:
                        begin
                            head_next    = '0;
                            fill_next    = '0;
                            started_next = 1'b0;
                        end
                        MODE_NOP:
                        begin
                        end
                    endcase
                end
            end
            ST_PULL:
            begin
                if (slot_ok)
                begin
                    iss.valid = 1'b1;
                    if (empty_reg)
                    begin
                        iss.meta.last = 1'b1;
                        iss.meta.none = 1'b1;
                        iss.meta.fill = fill_reg;
                        iss.meta.rdy  = (fill_reg >= {1'b0, eff_tgt});
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        mem_re        = 1'b1;
                        head_next     = h_inc;
                        fill_next     = fill_dec;
                        cnt_next      = cnt_reg - REQ_W'(1);
                        iss.meta.fill = fill_dec;
                        iss.meta.rdy  = (fill_dec >= {1'b0, eff_tgt});
                        iss.meta.last = (cnt_reg == REQ_W'(1));
                        if (cnt_reg == REQ_W'(1))
                        begin
                            started_next = 1'b1;
                            state_next   = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a write to the capacity or target register empties the ring
        if (cfg_we)
        begin
            unique case (idx_e)
                REG_CAPACITY:
                begin
                    cap_cfg_next = cfg_wdata;
                    head_next    = '0;
                    fill_next    = '0;
                end
                REG_TARGET:
                begin
                    tgt_cfg_next = cfg_wdata[TGT_W-1:0];
                    head_next    = '0;
                    fill_next    = '0;
                end
                REG_UNUSED2, REG_UNUSED3:
                begin
                end
            endcase
        end
    end

    a_head_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        SW'(head_reg) < SW'(eff_cap))
        else $error("head index outside the ring");

    a_pull_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PULL && !empty_reg) |-> cnt_reg != '0)
        else $error("pull running with nothing left to deliver");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (iss.valid && iss.meta.last) |=> state_reg == ST_IDLE)
        else $error("pull still running after its last item");

endmodule

/* hw/rtl/jitter_buffer_ring.sv */
// push: back to back, one push per cycle while no pull holds the input
// pull of n samples: holds the input until its last item is issued; each item is read
// into the memory's read register, then into the two-entry output queue on m_tvalid;
// one item per cycle while the sink keeps up, set by the single memory read port and queue
// reset: head, fill and start latch clear, capacity 4096, target 480; memory is not cleared
module jitter_buffer_ring
    import jbr_pkg::*;
#(
    parameter int DEPTH    = 4096,
    parameter int MAX_PULL = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [39:0]          s_tdata,   // sample_in[31:0], request_count[38:32]
    input  logic [1:0]           s_tuser,   // mode[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata,   // sample_out[31:0], fill_level[44:32]
    output logic [1:0]           m_tuser,   // none_delivered[0], ready_res[1]
    output logic                 m_tlast,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int AW = $clog2(DEPTH);

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [SAMPLE_W-1:0] mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [SAMPLE_W-1:0] mem_rdata;
    logic                slot_ok;
    issue_t              iss;

    jbr_ctrl #(
        .DEPTH    (DEPTH),
        .MAX_PULL (MAX_PULL),
        .AW       (AW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .mode          (s_tuser),
        .sample_in     (s_tdata[31:0]),
        .request_count (s_tdata[38:32]),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .slot_ok       (slot_ok),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_re        (mem_re),
        .mem_raddr     (mem_raddr),
        .iss           (iss)
    );

    jbr_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    jbr_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .iss      (iss),
        .rdata    (mem_rdata),
        .slot_ok  (slot_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* tb/sv/testbench.sv */
module testbench;
    import jbr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH = 4096;
    localparam int PULL_MAX   = 64;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD  = 400;
    localparam int DRAIN_WAIT = 16;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
        logic                none;
        logic [FILL_W-1:0]   fill;
        logic                rdy;
    } buf_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [39:0]          s_tdata = '0;
    logic [1:0]           s_tuser = MODE_PUSH;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [47:0]          m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_CAPACITY;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // shadow copy of the buffer state
    logic [SAMPLE_W-1:0] ring_words [RING_DEPTH];
    int                  ring_head = 0;
    int                  ring_fill = 0;
    bit                  ring_started = 1'b0;
    int                  cap_reg = 4096;
    int                  tgt_reg = 480;

    buf_result_t pending_results[$];

    bit quiet = 1'b0;
    bit stall_request = 1'b0;
    int items_sent = 0;
    int results_checked = 0;
    int empty_results = 0;
    int reg_writes = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    jitter_buffer_ring u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due", cycle_count,
                     pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int eff_target();
        return (tgt_reg == 0) ? 1 : tgt_reg;
    endfunction

    function automatic int eff_capacity();
        int t;
        int c;
        t = eff_target();
        c = (cap_reg > RING_DEPTH) ? RING_DEPTH : cap_reg;
        if (c <= t)
            c = t + 1;
        if (c > RING_DEPTH)
            c = RING_DEPTH;
        return c;
    endfunction

    function automatic void add_expected(logic [SAMPLE_W-1:0] smp, logic last, logic none);
        buf_result_t r;
        r.sample = smp;
        r.last   = last;
        r.none   = none;
        r.fill   = ring_fill[FILL_W-1:0];
        r.rdy    = (ring_fill >= eff_target());
        if (none)
            empty_results++;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_buffer_item(mode_t m, logic [SAMPLE_W-1:0] smp,
                                                logic [REQ_W-1:0] req_raw);
        int cap;
        int pos;
        int req;
        int n;
        cap = eff_capacity();
        case (m)
            MODE_PUSH:
            begin
                pos = (ring_head + ring_fill) % cap;
                ring_words[pos] = smp;
                ring_fill++;
                // full ring drops the oldest sample
                if (ring_fill > cap)
                begin
                    ring_head = (ring_head + 1) % cap;
                    ring_fill = cap;
                end
            end
            MODE_FLUSH:
            begin
                ring_head = 0;
                ring_fill = 0;
                ring_started = 1'b0;
            end
            MODE_PULL:
            begin
                req = (req_raw > PULL_MAX) ? PULL_MAX : int'(req_raw);
                n = (ring_fill < req) ? ring_fill : req;
                if (req == 0 || (!ring_started && ring_fill < eff_target()) || n == 0)
                    add_expected('0, 1'b1, 1'b1);
                else
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        smp = ring_words[ring_head % cap];
                        ring_head = (ring_head + 1) % cap;
                        ring_fill--;
                        add_expected(smp, (i == n - 1), 1'b0);
                    end
                    ring_started = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, buf_result_t want, buf_result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0s at cycle %0d: want sample=%h last=%b none=%b fill=%0d rdy=%b",
                     what, cycle_count, want.sample, want.last, want.none, want.fill, want.rdy,
                     "\n    got  sample=%h last=%b none=%b fill=%0d rdy=%b",
                     got.sample, got.last, got.none, got.fill, got.rdy);
    endtask

    always @(posedge clk)
    begin : result_check
        buf_result_t got;
        buf_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.sample = m_tdata[31:0];
            got.fill   = m_tdata[44:32];
            got.none   = m_tuser[0];
            got.rdy    = m_tuser[1];
            got.last   = m_tlast;
            results_checked++;
            if (pending_results.size() == 0)
                report_mismatch("unexpected item", '0, got);
            else
            begin
                want = pending_results.pop_front();
                if (got.none !== want.none || got.last !== want.last ||
                    got.fill !== want.fill || got.rdy !== want.rdy ||
                    (!want.none && got.sample !== want.sample))
                    report_mismatch("field mismatch", want, got);
            end
        end
    end

    // sink side: random stalls, plus one long hold-off on request
    initial
    begin : sink_ready
        int hold_cycles;
        forever
        begin
            if (stall_request)
            begin
                m_tready <= 1'b0;
                stall_request = 1'b0;
                for (hold_cycles = 0; hold_cycles < LONG_HOLD; hold_cycles++)
                    @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    task automatic send_item(mode_t m, logic [SAMPLE_W-1:0] smp, logic [REQ_W-1:0] req);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 6);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, req, smp};
        s_tuser  <= m;
        do
            @(posedge clk);
        while (!s_tready);
        predict_buffer_item(m, smp, req);
        items_sent++;
    endtask

    task automatic push_random(int count);
        for (int i = 0; i < count; i++)
            send_item(MODE_PUSH, $urandom(), REQ_W'($urandom_range(0, 127)));
    endtask

    task automatic pull(int req);
        send_item(MODE_PULL, $urandom(), REQ_W'(req));
    endtask

    // wait until every result is in and the block has gone quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[CFG_W-1:0];
        @(posedge clk);
        if (idx == REG_CAPACITY || idx == REG_TARGET)
        begin
            if (idx == REG_CAPACITY)
                cap_reg = val & 32'h1FFF;
            else
                tgt_reg = val & 32'hFFF;
            ring_head = 0;
            ring_fill = 0;
        end
        reg_writes++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // reset settings keep the gate shut, then a small target lets it open once
    task automatic test_reset_prefill();
        pull(10);
        send_item(MODE_PUSH, 32'h0000_0000, '0);
        send_item(MODE_PUSH, 32'hFFFF_FFFF, 7'h7F);
        push_random(20);
        pull(64);
        settle();
        write_reg(REG_TARGET, 24);
        push_random(23);
        pull(64);
        send_item(MODE_PUSH, 32'hA5A5_5A5A, '0);
        pull(64);
        send_item(MODE_PUSH, 32'h5A5A_A5A5, '0);
        pull(0);
        pull(127);
        pull(1);
    endtask

    // a short ring wraps many times and keeps dropping the oldest samples
    task automatic test_deep_wrap();
        settle();
        write_reg(REG_CAPACITY, 24);
        write_reg(REG_TARGET, 8);
        push_random(60);
        pull(64);
        push_random(3);
        pull(65);
        settle();
    endtask

    task automatic test_flush_and_nop();
        send_item(MODE_FLUSH, $urandom(), REQ_W'($urandom_range(0, 127)));
        pull(5);
        send_item(MODE_NOP, $urandom(), REQ_W'($urandom_range(0, 127)));
        push_random(3);
        pull(3);
        settle();
    endtask

    task automatic test_register_corners();
        write_reg(REG_TARGET, 0);
        write_reg(REG_CAPACITY, 1);
        send_item(MODE_PUSH, 32'h1111_1111, '0);
        send_item(MODE_PUSH, 32'h2222_2222, '0);
        send_item(MODE_PUSH, 32'h3333_3333, '0);
        pull(5);
        settle();
        write_reg(REG_CAPACITY, 0);
        write_reg(REG_CAPACITY, CAP_REG_MAX);
        write_reg(REG_TARGET, 4095);
        push_random(2);
        // start latch survives the register write
        pull(2);
        settle();
        write_reg(REG_CAPACITY, 5);
        write_reg(REG_TARGET, 5);
        send_item(MODE_FLUSH, '0, '0);
        push_random(6);
        pull(3);
        push_random(4);
        settle();
        write_reg(REG_UNUSED2, $urandom_range(0, 8191));
        write_reg(REG_UNUSED3, $urandom_range(0, 8191));
        pull(10);
        settle();
        write_reg(REG_CAPACITY, 2);
        write_reg(REG_TARGET, 1);
        push_random(2);
        pull(2);
        settle();
    endtask

    // sink holds off while pulls keep coming, so the block backs up
    task automatic test_backpressure();
        write_reg(REG_CAPACITY, 256);
        write_reg(REG_TARGET, 16);
        push_random(40);
        stall_request = 1'b1;
        pull(32);
        pull(64);
        push_random(4);
        pull(40);
        settle();
    endtask

    task automatic test_random_traffic();
        int cap_v;
        int tgt_v;
        int roll;
        int n_items;
        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase == 7)
                quiet = 1'b1;
            roll = $urandom_range(0, 9);
            if (roll < 7)
            begin
                cap_v = $urandom_range(2, 48);
                tgt_v = $urandom_range(1, cap_v);
            end
            else if (roll < 9)
            begin
                cap_v = $urandom_range(49, 4096);
                tgt_v = $urandom_range(0, 12);
            end
            else
            begin
                cap_v = $urandom_range(0, CAP_REG_MAX);
                tgt_v = $urandom_range(0, 4095);
            end
            settle();
            if ($urandom_range(0, 1) == 0)
            begin
                write_reg(REG_CAPACITY, cap_v);
                write_reg(REG_TARGET, tgt_v);
            end
            else
            begin
                write_reg(REG_TARGET, tgt_v);
                write_reg(REG_CAPACITY, cap_v);
            end
            n_items = $urandom_range(25, 32);
            for (int k = 0; k < n_items; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 57)
                    send_item(MODE_PUSH, $urandom(), REQ_W'($urandom_range(0, 127)));
                else if (roll < 95)
                begin
                    roll = $urandom_range(0, 9);
                    if (roll == 0)
                        pull(0);
                    else if (roll == 1)
                        pull($urandom_range(PULL_MAX + 1, 127));
                    else
                        pull($urandom_range(1, 24));
                end
                else if (roll < 97)
                    send_item(MODE_FLUSH, $urandom(), REQ_W'($urandom_range(0, 127)));
                else
                    send_item(MODE_NOP, $urandom(), REQ_W'($urandom_range(0, 127)));
            end
        end
        settle();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_prefill();
        test_deep_wrap();
        test_flush_and_nop();
        test_register_corners();
        test_backpressure();
        test_random_traffic();
        $display("sent %0d items, checked %0d results (%0d empty pulls), %0d register writes",
                 items_sent, results_checked, empty_results, reg_writes);
        $display("covered prefill gate, short-ring wrap, flush, register corners, long stall");
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/jbr_pkg.sv
hw/rtl/jbr_mem.sv
hw/rtl/jbr_outq.sv
hw/rtl/jbr_ctrl.sv
hw/rtl/jitter_buffer_ring.sv
tb/sv/testbench.sv
